// ===== rtl/dmw_pkg.sv =====
// ============================================================================
// dmw_pkg
// Shared types, codes and sizes for the decimal-mode word machine.
// ============================================================================
package dmw_pkg;

  // Memory geometry
  localparam int MEM_WORDS = 4096;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int PC_W      = AW + 1;
  localparam int WORD_W    = 64;

  // Decimal digit unit: bits shifted in per cycle and cycle count
  localparam int DAB_BITS  = 4;
  localparam int DAB_STEPS = WORD_W / DAB_BITS;
  localparam int DAB_CW    = $clog2(DAB_STEPS);
  localparam int DIGITS    = 5;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_EXEC    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACK   = 3'd0,
    ST_EXEC  = 3'd1,
    ST_OUT   = 3'd2,
    ST_HALT  = 3'd3,
    ST_BADOP = 3'd4,
    ST_RANGE = 3'd5
  } status_e;

  // Parameter modes
  localparam logic [3:0] MODE_POS = 4'd0;
  localparam logic [3:0] MODE_IMM = 4'd1;
  localparam logic [3:0] MODE_REL = 4'd2;

  // Opcodes
  localparam logic [6:0] OP_ADD  = 7'd1;
  localparam logic [6:0] OP_MUL  = 7'd2;
  localparam logic [6:0] OP_IN   = 7'd3;
  localparam logic [6:0] OP_OUT  = 7'd4;
  localparam logic [6:0] OP_JT   = 7'd5;
  localparam logic [6:0] OP_JF   = 7'd6;
  localparam logic [6:0] OP_LT   = 7'd7;
  localparam logic [6:0] OP_EQ   = 7'd8;
  localparam logic [6:0] OP_ARB  = 7'd9;
  localparam logic [6:0] OP_HALT = 7'd99;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_RESTART,
    S_FETCH,
    S_OPWORD,
    S_DABBLE,
    S_DECODE,
    S_PARAM,
    S_PARAM_RD,
    S_OPA,
    S_OPB,
    S_OPV,
    S_EXEC,
    S_MULW,
    S_DONE
  } state_e;

  // Decimal digits of an instruction word, least significant first
  typedef logic [DIGITS-1:0][3:0] digits_t;

endpackage

// ===== rtl/decimal_mode_word_vm_core.sv =====
// ============================================================================
// decimal_mode_word_vm_core
// 64-bit decimal-mode word machine: program image and working memory in
// synchronous RAMs, one instruction per execute word.
// ============================================================================
// Load and unknown words go from dispatch straight to the result. Restart sweeps
// the working copy, clearing its marks one entry per cycle.
// Execute time is set by the decimal digit unit, a RAM read for each parameter
// that is not immediate, the two operand reads and, for a multiply, the multiplier.
// One word at a time; a new word is taken while the last result waits.
// After reset a sweep clears both memories before any word is taken.
module decimal_mode_word_vm_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [dmw_pkg::AW-1:0]      address_i,
  input  logic signed [63:0]          data_i,
  input  logic signed [63:0]          input_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic signed [63:0]          out_value_o,
  output logic                        input_used_o,
  output logic [dmw_pkg::AW-1:0]      pc_after_o
);

  localparam int AW   = dmw_pkg::AW;
  localparam int PC_W = dmw_pkg::PC_W;
  localparam int WW   = dmw_pkg::WORD_W;

  dmw_pkg::state_e  state_q, state_d;
  dmw_pkg::req_e    req_q, req_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [WW-1:0]    data_q, data_d;
  logic [WW-1:0]    inval_q, inval_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [WW-1:0]    rb_q, rb_d;
  logic [PC_W-1:0]  extent_q, extent_d;
  logic [PC_W-1:0]  img_ext_q, img_ext_d;
  logic             stopped_q, stopped_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [1:0]       np_q, np_d;
  logic [1:0]       wr_idx_q, wr_idx_d;
  logic [1:0]       k_q, k_d;
  logic [2:0][AW-1:0] prm_q, prm_d;
  logic [WW-1:0]    va_q, va_d;
  logic [WW-1:0]    vb_q, vb_d;
  dmw_pkg::status_e res_status_q, res_status_d;
  logic [WW-1:0]    res_value_q, res_value_d;
  logic             res_used_q, res_used_d;

  logic             out_valid_q, out_valid_d;
  dmw_pkg::status_e out_status_q, out_status_d;
  logic [WW-1:0]    out_value_q, out_value_d;
  logic             out_used_q, out_used_d;
  logic [AW-1:0]    out_pc_q, out_pc_d;

  // Memory ports
  logic             img_we, work_we;
  logic [AW-1:0]    img_waddr, work_waddr, rd_addr;
  logic [WW-1:0]    img_wdata;
  logic [WW:0]      work_wdata;
  logic [WW-1:0]    img_rd;
  logic [WW:0]      work_rd;
  logic [WW-1:0]    rdata;

  // Units
  logic             dab_start, dab_done;
  dmw_pkg::digits_t digits;
  logic             mul_start, mul_done;
  logic [WW-1:0]    mul_res;

  // Decode and check signals
  logic             in_acc, out_free;
  logic [6:0]       op;
  logic             op_ok;
  logic [1:0]       op_np, op_wr;
  logic [3:0]       mode_cur;
  logic [PC_W-1:0]  paddr;
  logic             prm_bad, prm_rng, last_prm;
  logic [WW-1:0]    eff;
  logic             eff_rng;
  logic             jmp_take, jmp_rng;
  logic [PC_W-1:0]  pc_next;

  function automatic logic [PC_W-1:0] f_touch(input logic [PC_W-1:0] ext,
                                               input logic [PC_W-1:0] a);
    logic [PC_W-1:0] a1;
    a1 = a + 1'b1;
    return (a1 > ext) ? a1 : ext;
  endfunction

  // ---------------------------------------------------------------------------
  // Memories: pristine image and working copy with a written mark in the MSB
  // ---------------------------------------------------------------------------
  dmw_ram #(.WIDTH(WW), .DEPTH(dmw_pkg::MEM_WORDS)) u_img (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (img_wdata),
    .raddr_i (rd_addr),
    .rdata_o (img_rd)
  );

  dmw_ram #(.WIDTH(WW + 1), .DEPTH(dmw_pkg::MEM_WORDS)) u_work (
    .clk_i   (clk_i),
    .we_i    (work_we),
    .waddr_i (work_waddr),
    .wdata_i (work_wdata),
    .raddr_i (rd_addr),
    .rdata_o (work_rd)
  );

  assign rdata = work_rd[WW] ? work_rd[WW-1:0] : img_rd;

  dmw_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (dab_start),
    .word_i   (rdata),
    .done_o   (dab_done),
    .digits_o (digits)
  );

  dmw_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (va_q),
    .b_i     (vb_q),
    .done_o  (mul_done),
    .prod_o  (mul_res)
  );

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != dmw_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Instruction decode from the decimal digits
  // ---------------------------------------------------------------------------
  assign op = 7'(digits[1]) * 7'd10 + 7'(digits[0]);

  always_comb begin
    op_ok = 1'b1;
    op_np = 2'd0;
    op_wr = 2'd0;
    unique case (op)
      dmw_pkg::OP_ADD, dmw_pkg::OP_MUL, dmw_pkg::OP_LT, dmw_pkg::OP_EQ: begin
        op_np = 2'd3;
        op_wr = 2'd3;
      end
      dmw_pkg::OP_IN: begin
        op_np = 2'd1;
        op_wr = 2'd1;
      end
      dmw_pkg::OP_OUT, dmw_pkg::OP_ARB: op_np = 2'd1;
      dmw_pkg::OP_JT, dmw_pkg::OP_JF:   op_np = 2'd2;
      default: op_ok = 1'b0;
    endcase
  end

  // Parameter resolution checks
  assign mode_cur = digits[3'(k_q) + 3'd1];
  assign paddr    = pc_q + PC_W'(k_q);
  assign prm_bad  = (mode_cur > dmw_pkg::MODE_REL) ||
                    ((mode_cur == dmw_pkg::MODE_IMM) && (k_q == wr_idx_q));
  assign prm_rng  = (paddr >= PC_W'(dmw_pkg::MEM_WORDS));
  assign last_prm = (k_q == np_q);
  assign eff      = ((mode_cur == dmw_pkg::MODE_REL) ? rb_q : '0) + rdata;
  assign eff_rng  = (eff >= WW'(dmw_pkg::MEM_WORDS));
  assign jmp_take = ((op == dmw_pkg::OP_JT) == (va_q != '0));
  assign jmp_rng  = (vb_q >= WW'(dmw_pkg::MEM_WORDS));
  assign pc_next  = pc_q + PC_W'(np_q) + 1'b1;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dmw_pkg::S_CLEAR:
        if (cnt_q == AW'(dmw_pkg::MEM_WORDS - 1)) state_d = dmw_pkg::S_IDLE;
      dmw_pkg::S_IDLE:
        if (in_acc) state_d = dmw_pkg::S_DISPATCH;
      dmw_pkg::S_DISPATCH: begin
        unique case (req_q)
          dmw_pkg::REQ_RESTART: state_d = dmw_pkg::S_RESTART;
          dmw_pkg::REQ_EXEC:
            state_d = (stopped_q || (pc_q >= extent_q)) ? dmw_pkg::S_DONE
                                                        : dmw_pkg::S_FETCH;
          default: state_d = dmw_pkg::S_DONE;
        endcase
      end
      dmw_pkg::S_RESTART:
        if (cnt_q == AW'(dmw_pkg::MEM_WORDS - 1)) state_d = dmw_pkg::S_DONE;
      dmw_pkg::S_FETCH:  state_d = dmw_pkg::S_OPWORD;
      dmw_pkg::S_OPWORD: state_d = rdata[WW-1] ? dmw_pkg::S_DONE : dmw_pkg::S_DABBLE;
      dmw_pkg::S_DABBLE:
        if (dab_done) state_d = dmw_pkg::S_DECODE;
      dmw_pkg::S_DECODE:
        state_d = (op_ok && op != dmw_pkg::OP_HALT) ? dmw_pkg::S_PARAM : dmw_pkg::S_DONE;
      dmw_pkg::S_PARAM: begin
        if (prm_bad || prm_rng)                  state_d = dmw_pkg::S_DONE;
        else if (mode_cur != dmw_pkg::MODE_IMM)  state_d = dmw_pkg::S_PARAM_RD;
        else if (last_prm)                       state_d = dmw_pkg::S_OPA;
      end
      dmw_pkg::S_PARAM_RD: begin
        if (eff_rng)       state_d = dmw_pkg::S_DONE;
        else if (last_prm) state_d = dmw_pkg::S_OPA;
        else               state_d = dmw_pkg::S_PARAM;
      end
      dmw_pkg::S_OPA: state_d = dmw_pkg::S_OPB;
      dmw_pkg::S_OPB: state_d = dmw_pkg::S_OPV;
      dmw_pkg::S_OPV: state_d = dmw_pkg::S_EXEC;
      dmw_pkg::S_EXEC:
        state_d = (op == dmw_pkg::OP_MUL) ? dmw_pkg::S_MULW : dmw_pkg::S_DONE;
      dmw_pkg::S_MULW:
        if (mul_done) state_d = dmw_pkg::S_DONE;
      dmw_pkg::S_DONE:
        if (out_free) state_d = dmw_pkg::S_IDLE;
      default: state_d = dmw_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    req_d        = req_q;
    addr_d       = addr_q;
    data_d       = data_q;
    inval_d      = inval_q;
    pc_d         = pc_q;
    rb_d         = rb_q;
    extent_d     = extent_q;
    img_ext_d    = img_ext_q;
    stopped_d    = stopped_q;
    cnt_d        = cnt_q;
    np_d         = np_q;
    wr_idx_d     = wr_idx_q;
    k_d          = k_q;
    prm_d        = prm_q;
    va_d         = va_q;
    vb_d         = vb_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_used_d   = res_used_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_used_d   = out_used_q;
    out_pc_d     = out_pc_q;
    img_we       = 1'b0;
    img_waddr    = addr_q;
    img_wdata    = data_q;
    work_we      = 1'b0;
    work_waddr   = prm_q[2];
    work_wdata   = '0;
    rd_addr      = pc_q[AW-1:0];
    dab_start    = 1'b0;
    mul_start    = 1'b0;

    unique case (state_q)
      // Power-up sweep over both memories
      dmw_pkg::S_CLEAR: begin
        img_we     = 1'b1;
        img_waddr  = cnt_q;
        img_wdata  = '0;
        work_we    = 1'b1;
        work_waddr = cnt_q;
        cnt_d      = cnt_q + 1'b1;
      end
      dmw_pkg::S_IDLE: begin
        if (in_acc) begin
          req_d   = dmw_pkg::req_e'(req_type_i);
          addr_d  = address_i;
          data_d  = data_i;
          inval_d = input_value_i;
        end
      end
      dmw_pkg::S_DISPATCH: begin
        res_status_d = dmw_pkg::ST_ACK;
        res_value_d  = '0;
        res_used_d   = 1'b0;
        cnt_d        = '0;
        unique case (req_q)
          dmw_pkg::REQ_LOAD: begin
            img_we    = 1'b1;
            img_ext_d = f_touch(img_ext_q, {1'b0, addr_q});
            extent_d  = f_touch(extent_q, {1'b0, addr_q});
          end
          dmw_pkg::REQ_EXEC: begin
            if (stopped_q) begin
              res_status_d = dmw_pkg::ST_HALT;
            end else if (pc_q >= extent_q) begin
              res_status_d = dmw_pkg::ST_HALT;
              stopped_d    = 1'b1;
            end
          end
          default: ;
        endcase
      end
      // Clear the written marks of the working copy
      dmw_pkg::S_RESTART: begin
        work_we    = 1'b1;
        work_waddr = cnt_q;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == AW'(dmw_pkg::MEM_WORDS - 1)) begin
          pc_d      = '0;
          rb_d      = '0;
          extent_d  = img_ext_q;
          stopped_d = 1'b0;
        end
      end
      dmw_pkg::S_FETCH: ;
      dmw_pkg::S_OPWORD: begin
        if (rdata[WW-1]) begin
          res_status_d = dmw_pkg::ST_BADOP;
          stopped_d    = 1'b1;
        end else begin
          dab_start = 1'b1;
        end
      end
      dmw_pkg::S_DABBLE: ;
      dmw_pkg::S_DECODE: begin
        np_d     = op_np;
        wr_idx_d = op_wr;
        k_d      = 2'd1;
        prm_d    = '0;
        if (op == dmw_pkg::OP_HALT) begin
          res_status_d = dmw_pkg::ST_HALT;
          stopped_d    = 1'b1;
        end else if (!op_ok) begin
          res_status_d = dmw_pkg::ST_BADOP;
          stopped_d    = 1'b1;
        end
      end
      // Parameter word: mode check, range check, then read unless immediate
      dmw_pkg::S_PARAM: begin
        rd_addr = paddr[AW-1:0];
        if (prm_bad) begin
          res_status_d = dmw_pkg::ST_BADOP;
          stopped_d    = 1'b1;
        end else if (prm_rng) begin
          res_status_d = dmw_pkg::ST_RANGE;
          stopped_d    = 1'b1;
        end else begin
          extent_d = f_touch(extent_q, paddr);
          if (mode_cur == dmw_pkg::MODE_IMM) begin
            prm_d[k_q - 2'd1] = paddr[AW-1:0];
            k_d               = k_q + 2'd1;
          end
        end
      end
      // Effective address from the parameter word
      dmw_pkg::S_PARAM_RD: begin
        if (eff_rng) begin
          res_status_d = dmw_pkg::ST_RANGE;
          stopped_d    = 1'b1;
        end else begin
          extent_d          = f_touch(extent_q, {1'b0, eff[AW-1:0]});
          prm_d[k_q - 2'd1] = eff[AW-1:0];
          k_d               = k_q + 2'd1;
        end
      end
      dmw_pkg::S_OPA: rd_addr = prm_q[0];
      dmw_pkg::S_OPB: begin
        rd_addr = prm_q[1];
        va_d    = rdata;
      end
      dmw_pkg::S_OPV: vb_d = rdata;
      dmw_pkg::S_EXEC: begin
        res_status_d = dmw_pkg::ST_EXEC;
        pc_d         = pc_next;
        work_wdata   = {1'b1, va_q + vb_q};
        case (op)
          dmw_pkg::OP_ADD: work_we = 1'b1;
          dmw_pkg::OP_MUL: begin
            mul_start = 1'b1;
            pc_d      = pc_q;
          end
          dmw_pkg::OP_IN: begin
            work_we    = 1'b1;
            work_waddr = prm_q[0];
            work_wdata = {1'b1, inval_q};
            res_used_d = 1'b1;
          end
          dmw_pkg::OP_OUT: begin
            res_status_d = dmw_pkg::ST_OUT;
            res_value_d  = va_q;
          end
          dmw_pkg::OP_JT, dmw_pkg::OP_JF: begin
            if (jmp_take) begin
              if (jmp_rng) begin
                res_status_d = dmw_pkg::ST_RANGE;
                stopped_d    = 1'b1;
                pc_d         = pc_q;
              end else begin
                pc_d = vb_q[PC_W-1:0];
              end
            end
          end
          dmw_pkg::OP_LT: begin
            work_we    = 1'b1;
            work_wdata = {1'b1, WW'($signed(va_q) < $signed(vb_q))};
          end
          dmw_pkg::OP_EQ: begin
            work_we    = 1'b1;
            work_wdata = {1'b1, WW'(va_q == vb_q)};
          end
          default: rb_d = rb_q + va_q;
        endcase
      end
      dmw_pkg::S_MULW: begin
        if (mul_done) begin
          work_we    = 1'b1;
          work_wdata = {1'b1, mul_res};
          pc_d       = pc_next;
        end
      end
      // Hand the result to the output register
      dmw_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_used_d   = res_used_q;
          out_pc_d     = pc_q[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmw_pkg::S_CLEAR;
      pc_q        <= '0;
      rb_q        <= '0;
      extent_q    <= '0;
      img_ext_q   <= '0;
      stopped_q   <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      np_q        <= '0;
      wr_idx_q    <= '0;
      req_q       <= dmw_pkg::REQ_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      rb_q        <= rb_d;
      extent_q    <= extent_d;
      img_ext_q   <= img_ext_d;
      stopped_q   <= stopped_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      np_q        <= np_d;
      wr_idx_q    <= wr_idx_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    data_q       <= data_d;
    inval_q      <= inval_d;
    prm_q        <= prm_d;
    va_q         <= va_d;
    vb_q         <= vb_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_used_q   <= res_used_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_used_q   <= out_used_d;
    out_pc_q     <= out_pc_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_value_o  = out_value_q;
  assign input_used_o = out_used_q;
  assign pc_after_o   = out_pc_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_W'(dmw_pkg::MEM_WORDS))
    else $error("pc beyond memory");

  a_extent_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    extent_q <= PC_W'(dmw_pkg::MEM_WORDS) && img_ext_q <= PC_W'(dmw_pkg::MEM_WORDS))
    else $error("extent beyond memory");

  a_mul_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == dmw_pkg::S_MULW)
    else $error("multiplier finished outside its wait state");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == dmw_pkg::S_DONE)
    else $error("result word raised outside the done state");

endmodule

// ===== rtl/dmw_ram.sv =====
// ============================================================================
// dmw_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ============================================================================
module dmw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dmw_dabble.sv =====
// ============================================================================
// dmw_dabble
// Iterative binary to decimal unit: low five decimal digits of a word,
// four bits per cycle by shift-and-add-3.
// ============================================================================
module dmw_dabble (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dmw_pkg::WORD_W-1:0]  word_i,
  output logic                        done_o,
  output dmw_pkg::digits_t            digits_o
);

  logic [dmw_pkg::WORD_W-1:0] sh_q, sh_d;
  dmw_pkg::digits_t           bcd_q, bcd_d;
  logic [dmw_pkg::DAB_CW-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  dmw_pkg::digits_t           step;

  // Four dependent doubling steps; digits above the fifth drop out (mod 1e5)
  always_comb begin
    step = bcd_q;
    for (int j = 0; j < dmw_pkg::DAB_BITS; j++) begin
      for (int d = 0; d < dmw_pkg::DIGITS; d++) begin
        if (step[d] >= 4'd5) begin
          step[d] = step[d] + 4'd3;
        end
      end
      step = dmw_pkg::digits_t'({step, sh_q[dmw_pkg::WORD_W-1-j]});
    end
  end

  // Control
  always_comb begin
    sh_d   = sh_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = word_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = sh_q << dmw_pkg::DAB_BITS;
      bcd_d = step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == dmw_pkg::DAB_CW'(dmw_pkg::DAB_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

// ===== rtl/dmw_mul.sv =====
// ============================================================================
// dmw_mul
// Iterative 64x64 multiplier, low 64 bits of the product, built from three
// 32x32 partial products on one shared multiplier.
// ============================================================================
module dmw_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dmw_pkg::WORD_W-1:0]  a_i,
  input  logic [dmw_pkg::WORD_W-1:0]  b_i,
  output logic                        done_o,
  output logic [dmw_pkg::WORD_W-1:0]  prod_o
);

  localparam int HW = dmw_pkg::WORD_W / 2;

  logic [1:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [dmw_pkg::WORD_W-1:0] pp_q, pp_d;
  logic [dmw_pkg::WORD_W-1:0] acc_q, acc_d;
  logic [HW-1:0]              ma, mb;

  // Operand halves per phase: lo*lo, lo*hi, hi*lo
  always_comb begin
    case (cnt_q)
      2'd0:    begin ma = a_i[HW-1:0];             mb = b_i[HW-1:0]; end
      2'd1:    begin ma = a_i[HW-1:0];             mb = b_i[dmw_pkg::WORD_W-1:HW]; end
      default: begin ma = a_i[dmw_pkg::WORD_W-1:HW]; mb = b_i[HW-1:0]; end
    endcase
  end

  // Accumulate the partial product registered last cycle
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    pp_d   = dmw_pkg::WORD_W'(ma) * dmw_pkg::WORD_W'(mb);
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd1) begin
        acc_d = acc_q + pp_q;
      end else if (cnt_q != 2'd0) begin
        acc_d = acc_q + (pp_q << HW);
      end
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q  <= pp_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
